### sv/mlfs_pkg.sv
`default_nettype none

package mlfs_pkg;

  // Panel geometry and frame store layout
  localparam int PANEL_WIDTH  = 400;
  localparam int PANEL_HEIGHT = 240;
  localparam int ROW_BYTES    = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES  = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W       = $clog2(STORE_BYTES);

  // Field widths
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int COL_W   = X_W - 3;
  localparam int BYTE_W  = 8;
  localparam int OP_W    = 3;
  localparam int IN_TDATA_W = 48;

  // Configuration register indexes
  localparam logic [1:0] REG_VCOM_MASK = 2'd0;
  localparam logic [1:0] REG_WRITE_CMD = 2'd1;
  localparam logic [1:0] REG_CLEAR_CMD = 2'd2;

  localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  typedef enum logic [OP_W-1:0] {
    OP_PIXEL       = 3'd0,
    OP_FILL_RECT   = 3'd1,
    OP_CLEAR_BUF   = 3'd2,
    OP_FRAME_START = 3'd3,
    OP_SEND_LINE   = 3'd4,
    OP_FRAME_END   = 3'd5,
    OP_CLEAR_DISP  = 3'd6
  } op_t;

  // Input tdata layout, lowest field last
  typedef struct packed {
    logic [4:0]     pad;
    logic [Y_W-1:0] line_index;
    logic           pixel_color;
    logic [Y_W-1:0] y_last;
    logic [X_W-1:0] x_last;
    logic [Y_W-1:0] y_pos;
    logic [X_W-1:0] x_pos;
  } in_data_t;

  typedef enum logic [2:0] {
    ADDR_HOLD,
    ADDR_SWEEP_INIT,
    ADDR_INC,
    ADDR_RECT_INIT,
    ADDR_RECT_NEXT,
    ADDR_LINE_INIT
  } addr_op_t;

  typedef enum logic [2:0] {
    SRC_CMD_WRITE,
    SRC_CMD_CLEAR,
    SRC_ADDR,
    SRC_MEM,
    SRC_ZERO
  } out_sel_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_WIPE,
    ST_CLR_CMD,
    ST_RECT_RD,
    ST_RECT_WR,
    ST_FRAME,
    ST_LINE_ADDR,
    ST_LINE_RD,
    ST_LINE_EMIT,
    ST_TRAIL
  } state_t;

  typedef struct packed {
    logic     load;
    addr_op_t addr_op;
    logic     mem_re;
    logic     mem_we;
    logic     wr_fill;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
    logic     vcom_toggle;
    logic     vcom_clr;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic rect_empty;
    logic rect_done;
    logic line_valid;
    logic line_end;
    logic sweep_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### sv/memory_lcd_framebuffer_serializer.sv
// A pixel write or a rectangle fill reads and then rewrites each byte touched; a send line
//   emits 52 bytes, reading each row byte before it goes out, and stalls on a busy sink.
// Throughput is one request at a time; the single-port frame store sets the pace.
// Reset (rst_n low, synchronous) sweeps the 12000-byte store to 0xFF, one byte per
//   cycle, with in_tready low; clear buffer and clear display sweep alike.
// VCOM resets to 1; the config registers reset to 0x02, 0x01 and 0x04.
`default_nettype none

module memory_lcd_framebuffer_serializer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Drawing and link requests
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // x_pos[8:0], y_pos[16:9], x_last[25:17], y_last[33:26], pixel_color[34],
  // line_index[42:35], zero fill [47:43]
  input  wire logic [mlfs_pkg::IN_TDATA_W-1:0] in_tdata,
  // opcode[2:0]
  input  wire logic [mlfs_pkg::OP_W-1:0]       in_tuser,
  // Serial byte stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_byte[7:0]
  output logic [mlfs_pkg::BYTE_W-1:0]          out_tdata,
  output logic                                 out_tlast,
  // Configuration
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [3:0]                      cfg_paddr,
  input  wire logic [31:0]                     cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);

  mlfs_pkg::dp_cmd_t cmd;
  mlfs_pkg::dp_sts_t sts;

  logic [mlfs_pkg::BYTE_W-1:0] vcom_mask_r, write_cmd_r, clear_cmd_r;
  logic [mlfs_pkg::BYTE_W-1:0] rd_sel;
  logic [1:0]                  reg_idx;
  logic                        cfg_write;

  // Register file: a write lands on the access cycle, reads are immediate
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcom_mask_r <= 8'h02;
      write_cmd_r <= 8'h01;
      clear_cmd_r <= 8'h04;
    end else if (cfg_write) begin
      case (reg_idx)
        mlfs_pkg::REG_VCOM_MASK: vcom_mask_r <= cfg_pwdata[7:0];
        mlfs_pkg::REG_WRITE_CMD: write_cmd_r <= cfg_pwdata[7:0];
        mlfs_pkg::REG_CLEAR_CMD: clear_cmd_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mlfs_pkg::REG_VCOM_MASK: rd_sel = vcom_mask_r;
      mlfs_pkg::REG_WRITE_CMD: rd_sel = write_cmd_r;
      mlfs_pkg::REG_CLEAR_CMD: rd_sel = clear_cmd_r;
      default:                 rd_sel = '0;
    endcase
  end

  assign cfg_prdata = {24'd0, rd_sel};

  // Sequencer: decodes each request and steps the datapath
  mlfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Frame store, address walk, VCOM and the output register
  mlfs_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .vcom_mask      (vcom_mask_r),
    .write_cmd_bits (write_cmd_r),
    .clear_cmd_bits (clear_cmd_r),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast)
  );

endmodule

`default_nettype wire

### sv/mlfs_ctrl.sv
`default_nettype none

module mlfs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire mlfs_pkg::dp_sts_t sts,
  output mlfs_pkg::dp_cmd_t     cmd
);

  mlfs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlfs_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mlfs_pkg::ST_INIT: begin
        if (sts.sweep_done) state_nxt = mlfs_pkg::ST_IDLE;
      end
      mlfs_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = mlfs_pkg::ST_DISPATCH;
      end
      mlfs_pkg::ST_DISPATCH: begin
        case (sts.op)
          mlfs_pkg::OP_PIXEL, mlfs_pkg::OP_FILL_RECT: begin
            state_nxt = sts.rect_empty ? mlfs_pkg::ST_IDLE : mlfs_pkg::ST_RECT_RD;
          end
          mlfs_pkg::OP_CLEAR_BUF, mlfs_pkg::OP_CLEAR_DISP: state_nxt = mlfs_pkg::ST_WIPE;
          mlfs_pkg::OP_FRAME_START: state_nxt = mlfs_pkg::ST_FRAME;
          mlfs_pkg::OP_SEND_LINE: begin
            state_nxt = sts.line_valid ? mlfs_pkg::ST_LINE_ADDR : mlfs_pkg::ST_IDLE;
          end
          mlfs_pkg::OP_FRAME_END: state_nxt = mlfs_pkg::ST_TRAIL;
          default: state_nxt = mlfs_pkg::ST_IDLE;
        endcase
      end
      mlfs_pkg::ST_WIPE: begin
        if (sts.sweep_done) begin
          state_nxt = (sts.op == mlfs_pkg::OP_CLEAR_DISP) ? mlfs_pkg::ST_CLR_CMD
                                                           : mlfs_pkg::ST_IDLE;
        end
      end
      mlfs_pkg::ST_CLR_CMD: begin
        if (sts.out_free) state_nxt = mlfs_pkg::ST_TRAIL;
      end
      mlfs_pkg::ST_RECT_RD: state_nxt = mlfs_pkg::ST_RECT_WR;
      mlfs_pkg::ST_RECT_WR: begin
        state_nxt = sts.rect_done ? mlfs_pkg::ST_IDLE : mlfs_pkg::ST_RECT_RD;
      end
      mlfs_pkg::ST_FRAME: begin
        if (sts.out_free) state_nxt = mlfs_pkg::ST_IDLE;
      end
      mlfs_pkg::ST_LINE_ADDR: begin
        if (sts.out_free) state_nxt = mlfs_pkg::ST_LINE_RD;
      end
      mlfs_pkg::ST_LINE_RD: state_nxt = mlfs_pkg::ST_LINE_EMIT;
      mlfs_pkg::ST_LINE_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.line_end ? mlfs_pkg::ST_TRAIL : mlfs_pkg::ST_LINE_RD;
        end
      end
      mlfs_pkg::ST_TRAIL: begin
        if (sts.out_free) state_nxt = mlfs_pkg::ST_IDLE;
      end
      default: state_nxt = mlfs_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      mlfs_pkg::ST_INIT, mlfs_pkg::ST_WIPE: begin
        cmd.mem_we  = 1'b1;
        cmd.wr_fill = 1'b1;
        cmd.addr_op = mlfs_pkg::ADDR_INC;
      end
      mlfs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      mlfs_pkg::ST_DISPATCH: begin
        case (sts.op)
          mlfs_pkg::OP_PIXEL, mlfs_pkg::OP_FILL_RECT: begin
            if (!sts.rect_empty) cmd.addr_op = mlfs_pkg::ADDR_RECT_INIT;
          end
          mlfs_pkg::OP_CLEAR_BUF, mlfs_pkg::OP_CLEAR_DISP: begin
            cmd.addr_op = mlfs_pkg::ADDR_SWEEP_INIT;
          end
          mlfs_pkg::OP_SEND_LINE: begin
            if (sts.line_valid) cmd.addr_op = mlfs_pkg::ADDR_LINE_INIT;
          end
          default: ;
        endcase
      end
      mlfs_pkg::ST_CLR_CMD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = mlfs_pkg::SRC_CMD_CLEAR;
          cmd.vcom_clr = 1'b1;
        end
      end
      mlfs_pkg::ST_RECT_RD: cmd.mem_re = 1'b1;
      mlfs_pkg::ST_RECT_WR: begin
        cmd.mem_we  = 1'b1;
        cmd.addr_op = mlfs_pkg::ADDR_RECT_NEXT;
      end
      mlfs_pkg::ST_FRAME: begin
        if (sts.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_sel     = mlfs_pkg::SRC_CMD_WRITE;
          cmd.out_last    = 1'b1;
          cmd.vcom_toggle = 1'b1;
        end
      end
      mlfs_pkg::ST_LINE_ADDR: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = mlfs_pkg::SRC_ADDR;
        end
      end
      mlfs_pkg::ST_LINE_RD: cmd.mem_re = 1'b1;
      mlfs_pkg::ST_LINE_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = mlfs_pkg::SRC_MEM;
          if (!sts.line_end) cmd.addr_op = mlfs_pkg::ADDR_INC;
        end
      end
      mlfs_pkg::ST_TRAIL: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = mlfs_pkg::SRC_ZERO;
          cmd.out_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### sv/mlfs_datapath.sv
`default_nettype none

module mlfs_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire mlfs_pkg::dp_cmd_t                  cmd,
  output mlfs_pkg::dp_sts_t                       sts,
  input  wire logic [mlfs_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic [mlfs_pkg::OP_W-1:0]          in_tuser,
  input  wire logic [mlfs_pkg::BYTE_W-1:0]        vcom_mask,
  input  wire logic [mlfs_pkg::BYTE_W-1:0]        write_cmd_bits,
  input  wire logic [mlfs_pkg::BYTE_W-1:0]        clear_cmd_bits,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [mlfs_pkg::BYTE_W-1:0]             out_tdata,
  output logic                                    out_tlast
);

  localparam int ADDR_W = mlfs_pkg::ADDR_W;
  localparam int X_W    = mlfs_pkg::X_W;
  localparam int Y_W    = mlfs_pkg::Y_W;
  localparam int COL_W  = mlfs_pkg::COL_W;
  localparam int BYTE_W = mlfs_pkg::BYTE_W;

  logic [BYTE_W-1:0] frame_mem [mlfs_pkg::STORE_BYTES];

  mlfs_pkg::in_data_t in_d;
  mlfs_pkg::op_t      op_r;
  logic [X_W-1:0]     x0_r, x1_r, x1_sel, x1_clip;
  logic [Y_W-1:0]     y0_r, y1_r, y1_sel, y1_clip, line_r;
  logic               color_r;

  logic [ADDR_W-1:0]  addr_r, addr_nxt, row_base_r, row_base_nxt;
  logic [ADDR_W-1:0]  y_base, line_base;
  logic [COL_W-1:0]   col_r, col_nxt, col_first, col_end;
  logic [Y_W-1:0]     row_r, row_nxt;

  logic [BYTE_W-1:0]  rd_data_r, wr_byte, bit_mask, line_addr, out_byte;
  logic [2:0]         bit_lo, bit_hi;
  logic               vcom_r;
  logic               out_valid_r, out_last_r;
  logic [BYTE_W-1:0]  out_data_r;

  assign in_d = mlfs_pkg::in_data_t'(in_tdata);

  // Clip the far corner; a single pixel is a one-by-one rectangle
  always_comb begin
    if (mlfs_pkg::op_t'(in_tuser) == mlfs_pkg::OP_PIXEL) begin
      x1_sel = in_d.x_pos;
      y1_sel = in_d.y_pos;
    end else begin
      x1_sel = in_d.x_last;
      y1_sel = in_d.y_last;
    end
    x1_clip = (x1_sel >= X_W'(mlfs_pkg::PANEL_WIDTH))  ? X_W'(mlfs_pkg::PANEL_WIDTH - 1)
                                                        : x1_sel;
    y1_clip = (y1_sel >= Y_W'(mlfs_pkg::PANEL_HEIGHT)) ? Y_W'(mlfs_pkg::PANEL_HEIGHT - 1)
                                                        : y1_sel;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= mlfs_pkg::op_t'(in_tuser);
      x0_r    <= in_d.x_pos;
      y0_r    <= in_d.y_pos;
      x1_r    <= x1_clip;
      y1_r    <= y1_clip;
      color_r <= in_d.pixel_color;
      line_r  <= in_d.line_index;
    end
  end

  // Address walk
  assign col_first = x0_r[X_W-1:3];
  assign col_end   = x1_r[X_W-1:3];
  assign y_base    = ADDR_W'(y0_r) * ADDR_W'(mlfs_pkg::ROW_BYTES);
  assign line_base = ADDR_W'(line_r) * ADDR_W'(mlfs_pkg::ROW_BYTES);

  always_comb begin
    addr_nxt     = addr_r;
    row_base_nxt = row_base_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    case (cmd.addr_op)
      mlfs_pkg::ADDR_SWEEP_INIT: addr_nxt = '0;
      mlfs_pkg::ADDR_INC: begin
        addr_nxt = addr_r + 1'b1;
        col_nxt  = col_r + 1'b1;
      end
      mlfs_pkg::ADDR_RECT_INIT: begin
        row_base_nxt = y_base;
        row_nxt      = y0_r;
        col_nxt      = col_first;
        addr_nxt     = y_base + ADDR_W'(col_first);
      end
      mlfs_pkg::ADDR_RECT_NEXT: begin
        if (col_r == col_end) begin
          row_nxt      = row_r + 1'b1;
          row_base_nxt = row_base_r + ADDR_W'(mlfs_pkg::ROW_BYTES);
          col_nxt      = col_first;
          addr_nxt     = row_base_r + ADDR_W'(mlfs_pkg::ROW_BYTES) + ADDR_W'(col_first);
        end else begin
          col_nxt  = col_r + 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
      end
      mlfs_pkg::ADDR_LINE_INIT: begin
        col_nxt  = '0;
        addr_nxt = line_base;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else begin
      addr_r <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_base_r <= row_base_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
  end

  // Bits of the current byte that fall inside the rectangle, MSB is the leftmost pixel
  always_comb begin
    bit_lo = (col_r == col_first) ? x0_r[2:0] : 3'd0;
    bit_hi = (col_r == col_end)   ? x1_r[2:0] : 3'd7;
    for (int j = 0; j < 8; j++) begin
      bit_mask[7-j] = (3'(j) >= bit_lo) && (3'(j) <= bit_hi);
    end
    if (cmd.wr_fill) begin
      wr_byte = mlfs_pkg::FILL_BYTE;
    end else if (color_r) begin
      wr_byte = rd_data_r | bit_mask;
    end else begin
      wr_byte = rd_data_r & ~bit_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) frame_mem[addr_r] <= wr_byte;
    if (cmd.mem_re) rd_data_r <= frame_mem[addr_r];
  end

  // Line address goes out bit-reversed
  always_comb begin
    logic [BYTE_W-1:0] line_num;
    line_num = BYTE_W'(line_r) + 1'b1;
    for (int i = 0; i < BYTE_W; i++) begin
      line_addr[BYTE_W-1-i] = line_num[i];
    end
  end

  always_comb begin
    case (cmd.out_sel)
      mlfs_pkg::SRC_CMD_WRITE: out_byte = (vcom_r ? vcom_mask : '0) | write_cmd_bits;
      mlfs_pkg::SRC_CMD_CLEAR: out_byte = vcom_mask | clear_cmd_bits;
      mlfs_pkg::SRC_ADDR:      out_byte = line_addr;
      mlfs_pkg::SRC_MEM:       out_byte = rd_data_r;
      default:                 out_byte = mlfs_pkg::ZERO_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcom_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.vcom_clr) begin
        vcom_r <= 1'b0;
      end else if (cmd.vcom_toggle) begin
        vcom_r <= ~vcom_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= out_byte;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    sts            = '0;
    sts.op         = op_r;
    sts.rect_empty = (x0_r > x1_r) || (y0_r > y1_r);
    sts.rect_done  = (col_r == col_end) && (row_r == y1_r);
    sts.line_valid = line_r < Y_W'(mlfs_pkg::PANEL_HEIGHT);
    sts.line_end   = col_r == COL_W'(mlfs_pkg::ROW_BYTES - 1);
    sts.sweep_done = addr_r == ADDR_W'(mlfs_pkg::STORE_BYTES - 1);
    sts.out_free   = !out_valid_r || out_tready;
  end

  a_rw_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_we && cmd.mem_re))
    else $error("frame store read and write in the same cycle");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten before it was taken");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_we || cmd.mem_re) |-> (addr_r < ADDR_W'(mlfs_pkg::STORE_BYTES)))
    else $error("frame store access beyond the last byte");

  a_vcom_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.vcom_clr |=> !vcom_r)
    else $error("VCOM not low after clear display");

endmodule

`default_nettype wire

### sim/memory_lcd_framebuffer_serializer_tb.sv
`default_nettype none

module memory_lcd_framebuffer_serializer_tb;
  import mlfs_pkg::*;

  // Opcode that the block must ignore entirely
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  localparam int RX_HOLD_CYCLES = 400;      // long receiver hold-off
  localparam int SETTLE_CYCLES  = 16;       // settle time after the last owed byte arrives
  localparam int TAIL_CYCLES    = 64;       // watch for stray bytes at the end
  localparam int unsigned LIMIT_CYCLES = 2000000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [BYTE_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [3:0]            cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  memory_lcd_framebuffer_serializer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // x_pos, y_pos, x_last, y_last, pixel_color, line_index, zero fill
    .in_tuser   (in_tuser),     // opcode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // out_byte
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Panel model: 1 bit per pixel image, VCOM phase and the three command registers
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } link_byte_t;

  logic [BYTE_W-1:0] panel_image [STORE_BYTES];
  logic              panel_vcom;
  logic [BYTE_W-1:0] reg_vcom_mask;
  logic [BYTE_W-1:0] reg_write_cmd;
  logic [BYTE_W-1:0] reg_clear_cmd;

  logic [BYTE_W-1:0] emitted_bytes [$];     // bytes the latest request puts on the link
  link_byte_t        link_bytes_due [$];    // bytes still owed by the block, oldest first
  link_byte_t        due_byte;

  int          fault_count    = 0;
  int          requests_sent  = 0;
  int          bytes_checked  = 0;
  int          settings_count = 0;
  int          big_fills_left = 2;
  int          clears_left    = 6;
  int unsigned cycle_count    = 0;
  logic        steady_flow    = 1'b0;       // suppress idling on both sides
  logic        rx_hold_req    = 1'b0;       // ask the receiver for one long hold-off

  function automatic void wipe_image();
    for (int i = 0; i < STORE_BYTES; i++) panel_image[i] = FILL_BYTE;
  endfunction

  function automatic void plot(int unsigned x, int unsigned y, logic color);
    int unsigned       idx;
    logic [BYTE_W-1:0] mask;
    if (x >= PANEL_WIDTH || y >= PANEL_HEIGHT) return;
    idx  = y * ROW_BYTES + x / 8;
    mask = 8'h80 >> (x % 8);
    if (color) panel_image[idx] = panel_image[idx] | mask;
    else       panel_image[idx] = panel_image[idx] & ~mask;
  endfunction

  // Line address goes out LSB-first relative to its numeric value
  function automatic logic [BYTE_W-1:0] line_address(logic [Y_W-1:0] index);
    logic [BYTE_W-1:0] one_based;
    logic [BYTE_W-1:0] flipped;
    one_based = index + 8'd1;
    for (int i = 0; i < BYTE_W; i++) flipped[BYTE_W-1-i] = one_based[i];
    return flipped;
  endfunction

  // Advance the panel model by one request and collect the bytes it emits
  function automatic void panel_apply(logic [OP_W-1:0] opc, in_data_t f);
    int xb;
    int yb;
    emitted_bytes.delete();
    case (opc)
      OP_PIXEL: plot(f.x_pos, f.y_pos, f.pixel_color);
      OP_FILL_RECT: begin
        // clip the far corner to the panel; a reversed corner leaves the loops empty
        xb = (f.x_last >= PANEL_WIDTH)  ? PANEL_WIDTH - 1  : int'(f.x_last);
        yb = (f.y_last >= PANEL_HEIGHT) ? PANEL_HEIGHT - 1 : int'(f.y_last);
        for (int yy = int'(f.y_pos); yy <= yb; yy++)
          for (int xx = int'(f.x_pos); xx <= xb; xx++)
            plot(xx, yy, f.pixel_color);
      end
      OP_CLEAR_BUF: wipe_image();
      OP_FRAME_START: begin
        emitted_bytes.push_back((panel_vcom ? reg_vcom_mask : ZERO_BYTE) | reg_write_cmd);
        panel_vcom = ~panel_vcom;
      end
      OP_SEND_LINE: begin
        if (f.line_index < PANEL_HEIGHT) begin
          emitted_bytes.push_back(line_address(f.line_index));
          for (int i = 0; i < ROW_BYTES; i++)
            emitted_bytes.push_back(panel_image[int'(f.line_index) * ROW_BYTES + i]);
          emitted_bytes.push_back(ZERO_BYTE);
        end
      end
      OP_FRAME_END: emitted_bytes.push_back(ZERO_BYTE);
      OP_CLEAR_DISP: begin
        // VCOM is forced high for the command, then set low
        wipe_image();
        emitted_bytes.push_back(reg_vcom_mask | reg_clear_cmd);
        emitted_bytes.push_back(ZERO_BYTE);
        panel_vcom = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offer one request and hold it until accepted. A nonzero typed_n replaces the
  // model's bytes with values typed into the directed table (low byte first).
  task automatic offer_request(logic [OP_W-1:0] opc, in_data_t f,
                               logic [1:0] typed_n, logic [15:0] typed);
    while (!steady_flow && $urandom_range(0, 99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= opc;
    in_tdata  <= f;
    do @(posedge clk); while (!in_tready);
    panel_apply(opc, f);
    if (typed_n != 0) begin
      emitted_bytes.delete();
      for (int k = 0; k < typed_n; k++) emitted_bytes.push_back(typed[8*k +: 8]);
    end
    for (int k = 0; k < emitted_bytes.size(); k++)
      link_bytes_due.push_back('{emitted_bytes[k], k == emitted_bytes.size() - 1});
    requests_sent++;
  endtask

  // Drop the request line and wait until every owed byte has arrived
  task automatic drain_link();
    in_tvalid <= 1'b0;
    while (link_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic roll_request(output logic [OP_W-1:0] opc, output in_data_t f);
    int pick;
    pick = $urandom_range(0, 99);
    f = '0;
    f.x_pos       = $urandom_range(0, 511);
    f.y_pos       = $urandom_range(0, 255);
    f.x_last      = $urandom_range(0, 511);
    f.y_last      = $urandom_range(0, 255);
    f.pixel_color = $urandom_range(0, 1);
    f.line_index  = $urandom_range(0, 255);
    if (pick < 30) begin
      opc = OP_PIXEL;
      // mostly on the panel, now and then off it
      if ($urandom_range(0, 9) != 0) begin
        f.x_pos = $urandom_range(0, PANEL_WIDTH - 1);
        f.y_pos = $urandom_range(0, PANEL_HEIGHT - 1);
      end
    end else if (pick < 45) begin
      opc = OP_FILL_RECT;
      if (big_fills_left > 0 && $urandom_range(0, 39) == 0) begin
        big_fills_left--;
        f.x_pos  = $urandom_range(0, 7);
        f.x_last = $urandom_range(392, 511);
        f.y_pos  = $urandom_range(0, 15);
        f.y_last = $urandom_range(224, 255);
      end else begin
        // small rectangles; wrap-around and reversed corners come along for free
        f.x_last = f.x_pos + 9'($urandom_range(0, 23));
        f.y_last = f.y_pos + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 5) == 0) f.y_last = f.y_pos - 8'($urandom_range(1, 4));
      end
    end else if (pick < 48) begin
      if (clears_left > 0) begin
        clears_left--;
        opc = $urandom_range(0, 1) ? OP_CLEAR_BUF : OP_CLEAR_DISP;
      end else begin
        opc = OP_FRAME_END;
      end
    end else if (pick < 58) begin
      opc = OP_FRAME_START;
    end else if (pick < 90) begin
      opc = OP_SEND_LINE;
      if ($urandom_range(0, 11) != 0) f.line_index = $urandom_range(0, PANEL_HEIGHT - 1);
    end else if (pick < 97) begin
      opc = OP_FRAME_END;
    end else begin
      opc = OP_UNUSED;
    end
  endtask

  // Random traffic with refresh sequences mixed in; close with a frame end so the
  // block is known to be idle once that byte arrives
  task automatic run_random_phase(int count);
    logic [OP_W-1:0] opc;
    in_data_t        f;
    int              done;
    int              lines;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 7) == 0) begin
        lines = $urandom_range(2, 4);
        roll_request(opc, f);
        offer_request(OP_FRAME_START, f, 2'd0, 16'h0);
        repeat (lines) begin
          roll_request(opc, f);
          f.line_index = $urandom_range(0, PANEL_HEIGHT - 1);
          offer_request(OP_SEND_LINE, f, 2'd0, 16'h0);
        end
        roll_request(opc, f);
        offer_request(OP_FRAME_END, f, 2'd0, 16'h0);
        done += lines + 2;
      end else begin
        roll_request(opc, f);
        offer_request(opc, f, 2'd0, 16'h0);
        done++;
      end
    end
    roll_request(opc, f);
    offer_request(OP_FRAME_END, f, 2'd0, 16'h0);
  endtask

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  task automatic cfg_write(logic [1:0] idx, logic [BYTE_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'h0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(logic [1:0] idx, logic [BYTE_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {24'h0, val}) begin
      $error("cfg_prdata[%0d]: expected %08h, got %08h", idx, {24'h0, val}, cfg_prdata);
      fault_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(logic [BYTE_W-1:0] mask, logic [BYTE_W-1:0] wr,
                             logic [BYTE_W-1:0] clr);
    cfg_write(REG_VCOM_MASK, mask);
    cfg_write(REG_WRITE_CMD, wr);
    cfg_write(REG_CLEAR_CMD, clr);
    reg_vcom_mask = mask;
    reg_write_cmd = wr;
    reg_clear_cmd = clr;
    cfg_read_check(REG_VCOM_MASK, mask);
    cfg_read_check(REG_WRITE_CMD, wr);
    cfg_read_check(REG_CLEAR_CMD, clr);
    settings_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed requests. Typed bytes hold for the reset register values; rows with
  // typed_n of zero are checked against the panel model.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [OP_W-1:0] opc;
    logic [X_W-1:0]  x0;
    logic [Y_W-1:0]  y0;
    logic [X_W-1:0]  x1;
    logic [Y_W-1:0]  y1;
    logic            color;
    logic [Y_W-1:0]  line_no;
    logic [1:0]      typed_n;
    logic [15:0]     typed;
  } script_row_t;

  localparam int SCRIPT_LEN = 27;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{OP_FRAME_START, 9'd0,   8'd0,   9'd0,   8'd0,   1'b0, 8'd0,   2'd1, 16'h0003}, // VCOM high
    '{OP_FRAME_START, 9'd0,   8'd0,   9'd0,   8'd0,   1'b0, 8'd0,   2'd1, 16'h0001}, // VCOM low
    '{OP_FRAME_END,   9'd0,   8'd0,   9'd0,   8'd0,   1'b0, 8'd0,   2'd1, 16'h0000},
    '{OP_SEND_LINE,   9'd0,   8'd0,   9'd0,   8'd0,   1'b0, 8'd0,   2'd0, 16'h0000}, // white row
    '{OP_PIXEL,       9'd0,   8'd0,   9'd0,   8'd0,   1'b0, 8'd0,   2'd0, 16'h0000}, // corners
    '{OP_PIXEL,       9'd399, 8'd239, 9'd0,   8'd0,   1'b0, 8'd0,   2'd0, 16'h0000},
    '{OP_PIXEL,       9'd400, 8'd0,   9'd0,   8'd0,   1'b0, 8'd0,   2'd0, 16'h0000}, // off panel
    '{OP_PIXEL,       9'd511, 8'd255, 9'd0,   8'd0,   1'b0, 8'd0,   2'd0, 16'h0000},
    '{OP_PIXEL,       9'd7,   8'd240, 9'd0,   8'd0,   1'b0, 8'd0,   2'd0, 16'h0000},
    '{OP_PIXEL,       9'd7,   8'd0,   9'd0,   8'd0,   1'b0, 8'd0,   2'd0, 16'h0000},
    '{OP_PIXEL,       9'd0,   8'd0,   9'd0,   8'd0,   1'b1, 8'd0,   2'd0, 16'h0000}, // set back
    '{OP_FILL_RECT,   9'd3,   8'd1,   9'd20,  8'd2,   1'b0, 8'd0,   2'd0, 16'h0000},
    '{OP_FILL_RECT,   9'd10,  8'd3,   9'd5,   8'd3,   1'b0, 8'd0,   2'd0, 16'h0000}, // x reversed
    '{OP_FILL_RECT,   9'd0,   8'd6,   9'd399, 8'd4,   1'b0, 8'd0,   2'd0, 16'h0000}, // y reversed
    '{OP_FILL_RECT,   9'd390, 8'd236, 9'd511, 8'd255, 1'b0, 8'd0,   2'd0, 16'h0000}, // clipped
    '{OP_FILL_RECT,   9'd450, 8'd0,   9'd500, 8'd0,   1'b0, 8'd0,   2'd0, 16'h0000}, // off panel
    '{OP_SEND_LINE,   9'd0,   8'd0,   9'd0,   8'd0,   1'b0, 8'd0,   2'd0, 16'h0000},
    '{OP_SEND_LINE,   9'd0,   8'd0,   9'd0,   8'd0,   1'b0, 8'd1,   2'd0, 16'h0000},
    '{OP_SEND_LINE,   9'd0,   8'd0,   9'd0,   8'd0,   1'b0, 8'd239, 2'd0, 16'h0000},
    '{OP_SEND_LINE,   9'd0,   8'd0,   9'd0,   8'd0,   1'b0, 8'd240, 2'd0, 16'h0000}, // no output
    '{OP_SEND_LINE,   9'd511, 8'd255, 9'd511, 8'd255, 1'b1, 8'd255, 2'd0, 16'h0000},
    '{OP_UNUSED,      9'd511, 8'd255, 9'd511, 8'd255, 1'b1, 8'd255, 2'd0, 16'h0000}, // ignored
    '{OP_CLEAR_BUF,   9'd0,   8'd0,   9'd0,   8'd0,   1'b0, 8'd0,   2'd0, 16'h0000},
    '{OP_SEND_LINE,   9'd0,   8'd0,   9'd0,   8'd0,   1'b0, 8'd1,   2'd0, 16'h0000},
    '{OP_CLEAR_DISP,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, 8'd0,   2'd2, 16'h0006}, // cmd, 0x00
    '{OP_FRAME_START, 9'd0,   8'd0,   9'd0,   8'd0,   1'b0, 8'd0,   2'd1, 16'h0001}, // VCOM low
    '{OP_SEND_LINE,   9'd0,   8'd0,   9'd0,   8'd0,   1'b0, 8'd238, 2'd0, 16'h0000}
  };

  // ---------------------------------------------------------------------------
  // Byte sink: random backpressure plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      out_tready <= steady_flow || ($urandom_range(0, 99) >= 21);
    end
  end

  // Compare every accepted byte with the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      bytes_checked++;
      if (link_bytes_due.size() == 0) begin
        $error("out_tdata: unexpected byte %02h with no request pending", out_tdata);
        fault_count++;
      end else begin
        due_byte = link_bytes_due.pop_front();
        if (out_tdata !== due_byte.value) begin
          $error("out_tdata: expected %02h, got %02h", due_byte.value, out_tdata);
          fault_count++;
        end
        if (out_tlast !== due_byte.last) begin
          $error("out_tlast: expected %0b, got %0b", due_byte.last, out_tlast);
          fault_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_data_t req;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    wipe_image();
    panel_vcom    = 1'b1;
    reg_vcom_mask = 8'h02;
    reg_write_cmd = 8'h01;
    reg_clear_cmd = 8'h04;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers must come out of reset at their defaults
    cfg_read_check(REG_VCOM_MASK, 8'h02);
    cfg_read_check(REG_WRITE_CMD, 8'h01);
    cfg_read_check(REG_CLEAR_CMD, 8'h04);
    settings_count++;

    // Walk the directed table; the first request waits out the store sweep
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      req             = '0;
      req.x_pos       = SCRIPT[r].x0;
      req.y_pos       = SCRIPT[r].y0;
      req.x_last      = SCRIPT[r].x1;
      req.y_last      = SCRIPT[r].y1;
      req.pixel_color = SCRIPT[r].color;
      req.line_index  = SCRIPT[r].line_no;
      offer_request(SCRIPT[r].opc, req, SCRIPT[r].typed_n, SCRIPT[r].typed);
    end
    drain_link();

    // All-ones mask with empty command bits
    load_config(8'hFF, 8'h00, 8'h00);
    run_random_phase(70);
    drain_link();

    // Empty mask with all-ones command bits; hold the sink off while line
    // requests pile up so the block backs up into its request port
    load_config(8'h00, 8'hFF, 8'hFF);
    rx_hold_req = 1'b1;
    req = '0;
    repeat (3) begin
      req.line_index = $urandom_range(0, PANEL_HEIGHT - 1);
      offer_request(OP_SEND_LINE, req, 2'd0, 16'h0);
    end
    run_random_phase(64);
    drain_link();

    // Random settings with both sides running flat out
    load_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    steady_flow = 1'b1;
    run_random_phase(70);
    drain_link();
    steady_flow = 1'b0;

    load_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    run_random_phase(50);
    drain_link();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests, %0d link bytes checked, %0d register settings.",
             requests_sent, bytes_checked, settings_count);
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
